/* sv/shms_pkg.sv */
// shared widths, register indexes, reset values and status codes of the stepper sequencer
package shms_pkg;

  localparam int unsigned CNT_W  = 24;
  localparam int unsigned TGT_W  = 24;
  localparam int unsigned HALF_W = 8;
  localparam int unsigned SEL_W  = 4;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned SENS_W = 8;
  localparam int unsigned STAT_W = 3;

  localparam int unsigned CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SENSOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIMEOUT = 3'd4;

  localparam logic [TGT_W-1:0]  RST_STEP_TARGET  = '0;
  localparam logic [HALF_W-1:0] RST_HALF_PERIOD  = 8'd100;
  localparam logic [SEL_W-1:0]  RST_STOP_SENSOR  = 4'hF;
  localparam logic              RST_STOP_LEVEL   = 1'b0;
  localparam logic [TMO_W-1:0]  RST_MOVE_TIMEOUT = 16'd1000;

  localparam logic [TMO_W-1:0] HOME_TIMEOUT    = 16'd1000;
  localparam logic [2:0]       HOME_SENSOR_BIT = 3'd0;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TMO_W-1:0] TMO_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_NONE     = 3'd0,
    ST_COUNT    = 3'd1,
    ST_SENSOR   = 3'd2,
    ST_HOME_TMO = 3'd3,
    ST_MOVE_TMO = 3'd4
  } status_e;

endpackage

/* sv/shms_cfg_if.sv */
// configuration write channel of the stepper sequencer
interface shms_cfg_if import shms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink (input valid, input reg_idx, input wdata, output ready);
endinterface

/* sv/shms_in_if.sv */
// input item channel: start request, time base ticks and sensor bits
interface shms_in_if import shms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              start_req;
  logic              us_tick;
  logic              tick_100ms;
  logic [SENS_W-1:0] sensor_byte;

  modport source (output valid, output start_req, output us_tick, output tick_100ms,
                  output sensor_byte, input ready);
  modport sink (input valid, input start_req, input us_tick, input tick_100ms,
                input sensor_byte, output ready);
endinterface

/* sv/shms_out_if.sv */
// result channel: step, direction and enable lines plus move status
interface shms_out_if import shms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              step_pulse;
  logic              direction;
  logic              motor_enable;
  logic              busy_res;
  logic              done_res;
  logic [STAT_W-1:0] end_status;

  modport source (output valid, output step_pulse, output direction, output motor_enable,
                  output busy_res, output done_res, output end_status, input ready);
  modport sink (input valid, input step_pulse, input direction, input motor_enable,
                input busy_res, input done_res, input end_status, output ready);
endinterface

/* sv/stepper_home_and_move_sequencer.sv */
// Stepper home-and-move sequencer. Each input beat carries one sample of the microsecond and
// 100 ms time base together with the opto sensor byte, and gives exactly one result beat with
// the step line, direction, motor enable, busy, done and end status after that sample. A start
// beat in idle latches direction from the sign of step_target and begins homing: pulses repeat
// until home sensor bit reads 0 (or fail with home timeout after more than 1000 ticks of
// 100 ms), then a counted move runs until the target count, the selected stop sensor level or
// move_timeout. Sensors and timeouts are checked on the beat that ends a low half. One beat is
// taken every clock: the state update is a single pass of counters and compares into the
// state and result registers, and the result register lets a new beat in while the previous
// result is being taken, so only a stalled result side holds off the input. Configuration
// writes are taken every clock and act at once.
module stepper_home_and_move_sequencer import shms_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  shms_cfg_if.sink   cfg_i,
  shms_in_if.sink    in_i,
  shms_out_if.source out_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HOME = 2'd1,
    PH_MOVE = 2'd2
  } phase_e;

  // configuration registers
  logic [TGT_W-1:0]  target_q;
  logic [HALF_W-1:0] half_q;
  logic [SEL_W-1:0]  stop_sel_q;
  logic              stop_lvl_q;
  logic [TMO_W-1:0]  move_tmo_q;

  // sequencer state
  phase_e            phase_q, phase_d;
  logic [HALF_W-1:0] half_cnt_q, half_cnt_d;
  logic              pulse_q, pulse_d;
  logic [CNT_W-1:0]  pulses_q, pulses_d;
  logic [TMO_W-1:0]  elapsed_q, elapsed_d;
  logic              dir_q, dir_d;
  status_e           status_q, status_d;
  logic              done_d;

  // result register
  logic              out_valid_q;
  logic              out_done_q;

  logic              in_acc;
  logic              cfg_acc;
  logic [HALF_W-1:0] half_limit;
  logic              half_end;
  logic [TGT_W-1:0]  tgt_mag;
  logic              tgt_pos;
  logic [CNT_W-1:0]  pulses_inc;
  logic              stop_hit;
  logic              count_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_acc     = in_i.valid & in_i.ready;

  assign half_limit = (half_q == '0) ? HALF_W'(1) : half_q;
  assign half_end   = ({1'b0, half_cnt_q} + (HALF_W+1)'(1)) >= {1'b0, half_limit};

  assign tgt_mag = target_q[TGT_W-1] ? (~target_q + TGT_W'(1)) : target_q;
  assign tgt_pos = (target_q != '0) & ~target_q[TGT_W-1];

  assign pulses_inc = (pulses_q != CNT_MAX) ? (pulses_q + CNT_W'(1)) : pulses_q;
  assign stop_hit   = ~stop_sel_q[SEL_W-1] &
                      (in_i.sensor_byte[stop_sel_q[2:0]] == stop_lvl_q);
  assign count_hit  = CMP_W'(pulses_inc) >= CMP_W'(tgt_mag);

  always_comb begin
    phase_d    = phase_q;
    half_cnt_d = half_cnt_q;
    pulse_d    = pulse_q;
    pulses_d   = pulses_q;
    elapsed_d  = elapsed_q;
    dir_d      = dir_q;
    status_d   = status_q;
    done_d     = 1'b0;

    if (phase_q == PH_HOME || phase_q == PH_MOVE) begin
      if (in_i.tick_100ms && elapsed_q != TMO_MAX) begin
        elapsed_d = elapsed_q + TMO_W'(1);
      end
      if (in_i.us_tick) begin
        if (!half_end) begin
          half_cnt_d = half_cnt_q + HALF_W'(1);
        end else begin
          half_cnt_d = '0;
          if (pulse_q) begin
            pulse_d = 1'b0;
          end else if (phase_q == PH_HOME) begin
            // timeout compares the already updated elapsed count
            priority if (!in_i.sensor_byte[HOME_SENSOR_BIT]) begin
              phase_d  = PH_MOVE;
              pulses_d = '0;
              pulse_d  = 1'b1;
            end else if (elapsed_d > HOME_TIMEOUT) begin
              phase_d  = PH_IDLE;
              status_d = ST_HOME_TMO;
              done_d   = 1'b1;
            end else begin
              pulse_d = 1'b1;
            end
          end else begin
            pulses_d = pulses_inc;
            priority if (stop_hit) begin
              phase_d  = PH_IDLE;
              status_d = ST_SENSOR;
              done_d   = 1'b1;
            end else if (count_hit) begin
              phase_d  = PH_IDLE;
              status_d = ST_COUNT;
              done_d   = 1'b1;
            end else if (elapsed_d > move_tmo_q) begin
              phase_d  = PH_IDLE;
              status_d = ST_MOVE_TMO;
              done_d   = 1'b1;
            end else begin
              pulse_d = 1'b1;
            end
          end
        end
      end
    end else begin
      phase_d = PH_IDLE;
      if (in_i.start_req) begin
        dir_d      = ~tgt_pos;
        elapsed_d  = '0;
        half_cnt_d = '0;
        pulse_d    = 1'b1;
        pulses_d   = '0;
        status_d   = ST_NONE;
        phase_d    = PH_HOME;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= RST_STEP_TARGET;
      half_q      <= RST_HALF_PERIOD;
      stop_sel_q  <= RST_STOP_SENSOR;
      stop_lvl_q  <= RST_STOP_LEVEL;
      move_tmo_q  <= RST_MOVE_TIMEOUT;
      phase_q     <= PH_IDLE;
      half_cnt_q  <= '0;
      pulse_q     <= 1'b0;
      pulses_q    <= '0;
      elapsed_q   <= '0;
      dir_q       <= 1'b0;
      status_q    <= ST_NONE;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_i.reg_idx)
          REG_STEP_TARGET:  target_q   <= cfg_i.wdata[TGT_W-1:0];
          REG_HALF_PERIOD:  half_q     <= cfg_i.wdata[HALF_W-1:0];
          REG_STOP_SENSOR:  stop_sel_q <= cfg_i.wdata[SEL_W-1:0];
          REG_STOP_LEVEL:   stop_lvl_q <= cfg_i.wdata[0];
          REG_MOVE_TIMEOUT: move_tmo_q <= cfg_i.wdata[TMO_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_q     <= phase_d;
        half_cnt_q  <= half_cnt_d;
        pulse_q     <= pulse_d;
        pulses_q    <= pulses_d;
        elapsed_q   <= elapsed_d;
        dir_q       <= dir_d;
        status_q    <= status_d;
        out_done_q  <= done_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the result beat mirrors the state after the last accepted item
  assign out_o.valid        = out_valid_q;
  assign out_o.step_pulse   = pulse_q;
  assign out_o.direction    = dir_q;
  assign out_o.motor_enable = (phase_q != PH_IDLE);
  assign out_o.busy_res     = (phase_q != PH_IDLE);
  assign out_o.done_res     = out_done_q;
  assign out_o.end_status   = status_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done_q |-> (phase_q == PH_IDLE && status_q != ST_NONE))
    else $error("move ended but sequencer still busy or status empty");

  a_idle_no_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> !pulse_q)
    else $error("step line high while idle");

  a_start_homes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_IDLE && in_i.start_req) |=> (phase_q == PH_HOME && pulse_q))
    else $error("start beat did not begin homing");

  a_state_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> ($stable(phase_q) && $stable(pulses_q) && $stable(half_cnt_q)))
    else $error("state moved without an accepted beat");

  a_move_from_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MOVE && $past(phase_q) != PH_MOVE) |-> ($past(phase_q) == PH_HOME))
    else $error("counted move entered without homing");

endmodule
